// File: hdl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

    // Default cartridge sizes, in 8 KB banks
    localparam int ROM_BANKS_DEF = 16;
    localparam int RAM_BANKS_DEF = 16;

    // Bus commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OPLL0 = 1'b0;
    localparam logic CFG_OPLL1 = 1'b1;

    // Address decode constants
    localparam logic [15:0] RAM_EN_ADDR     = 16'h48FB;
    localparam logic [15:0] RAM_EN_MASK     = 16'hF8FF;
    localparam logic [15:0] BANK1_MASK      = 16'hF8FC;
    localparam logic [15:0] BANK1_ADDR      = 16'h48FC;
    localparam logic [15:0] BANK0_MASK      = 16'h1800;
    localparam logic [15:0] BANK0_ADDR      = 16'h1000;
    localparam logic [7:0]  SCC_BANK_MASK   = 8'h3F;
    localparam logic [15:0] SCC_LO          = 16'h9800;
    localparam logic [15:0] SCC_HI          = 16'hA000;
    localparam logic [15:0] OPLL0_ADDR      = 16'h7FF4;
    localparam logic [15:0] OPLL1_ADDR      = 16'h7FF2;
    localparam logic [15:0] OPLL_MASK       = 16'hFFFE;
    localparam logic [15:0] WR_LO           = 16'h4800;
    localparam logic [15:0] WR_HI           = 16'hC000;
    localparam logic [15:0] RAM_WR_LO       = 16'h6000;
    localparam logic [2:0]  SCC_EN_PAGE     = 3'd4;

    typedef enum logic [1:0] {
        MEM_NONE = 2'd0,
        MEM_ROM  = 2'd1,
        MEM_RAM  = 2'd2,
        MEM_SCC  = 2'd3
    } t_mem_sel;

    typedef enum logic [1:0] {
        OPLL_NONE = 2'd0,
        OPLL_0    = 2'd1,
        OPLL_1    = 2'd2
    } t_opll_sel;

    // Mapper state as seen by the decoder
    typedef struct packed {
        logic [3:0][7:0] bank;
        logic            ram_en;
        logic            scc_en;
        logic            opll0;
        logic            opll1;
    } t_state;

    // State changes requested by one write
    typedef struct packed {
        logic       bank_we;
        logic [1:0] bank_idx;
        logic [7:0] bank_data;
        logic       ram_we;
        logic       ram_val;
        logic       scc_we;
        logic       scc_val;
    } t_upd;

    typedef struct packed {
        t_mem_sel    mem_select;
        logic        mem_write;
        logic [20:0] mem_address;
        t_opll_sel   opll_select;
        logic        opll_port;
        logic [7:0]  data_out;
        logic        invalidate;
        logic [2:0]  invalidate_page;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/cartridge_bank_mapper.sv
`default_nettype none

// Bus-side mapper for an 8 KB banked cartridge with extra RAM, an SCC sound
// window and two FM chip tunnels. Each accepted word is one CPU access; it
// produces exactly one result word naming the target (ROM, RAM, SCC or none),
// its 21-bit byte address, any FM chip port write, and a cache-invalidate
// flag when a bank register changes value. A word passes the input register,
// then the result register; throughput is one word per cycle while the output
// is not stalled, set by the single-pass decode between those registers, with
// the mapper state updated as each word moves into the result register so
// the next word sees it. The input side keeps accepting while a finished
// result waits, until both registers are full. RomBanks and RamBanks give the
// ROM size and the RAM bank count used to fold bank values onto RAM. The opll
// present registers may be written only while the block is idle.
module cartridge_bank_mapper #(
    parameter int RomBanks = cbm_pkg::ROM_BANKS_DEF,
    parameter int RamBanks = cbm_pkg::RAM_BANKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    // result word channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_mem_select,
    output logic             o_mem_write,
    output logic [20:0]      o_mem_address,
    output logic [1:0]       o_opll_select,
    output logic             o_opll_port,
    output logic [7:0]       o_data_out,
    output logic             o_invalidate,
    output logic [2:0]       o_invalidate_page,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_wdata
);

    logic             r_s1_valid;
    logic             r_s1_command;
    logic [15:0]      r_s1_address;
    logic [7:0]       r_s1_data;
    logic             r_out_valid;
    cbm_pkg::t_result r_out;

    logic             out_free;
    logic             s1_move;
    logic             in_take;
    cbm_pkg::t_state  state;
    cbm_pkg::t_result result;
    cbm_pkg::t_upd    upd;

    // Result register frees when empty or taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // hold stage 1 only while the result register is blocked
            if (out_free) begin
                r_s1_valid <= in_take;
            end else if (in_take) begin
                r_s1_valid <= 1'b1;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_command <= i_command;
            r_s1_address <= i_address;
            r_s1_data    <= i_write_data;
        end
        if (s1_move) begin
            r_out <= result;
        end
    end

    cbm_decode #(
        .RomBanks (RomBanks),
        .RamBanks (RamBanks)
    ) u_decode (
        .i_command    (r_s1_command),
        .i_address    (r_s1_address),
        .i_write_data (r_s1_data),
        .i_state      (state),
        .o_result     (result),
        .o_upd        (upd)
    );

    // commit state changes as the word advances into the result register
    cbm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd_en    (s1_move),
        .i_upd       (upd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_state     (state)
    );

    assign o_out_valid       = r_out_valid;
    assign o_mem_select      = r_out.mem_select;
    assign o_mem_write       = r_out.mem_write;
    assign o_mem_address     = r_out.mem_address;
    assign o_opll_select     = r_out.opll_select;
    assign o_opll_port       = r_out.opll_port;
    assign o_data_out        = r_out.data_out;
    assign o_invalidate      = r_out.invalidate;
    assign o_invalidate_page = r_out.invalidate_page;

endmodule

`default_nettype wire

// File: hdl/cbm_regs.sv
`default_nettype none

module cbm_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_upd_en,
    input  wire cbm_pkg::t_upd i_upd,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic          i_cfg_wdata,
    output cbm_pkg::t_state    o_state
);

    logic [3:0][7:0] r_bank;
    logic            r_ram_en;
    logic            r_scc_en;
    logic            r_opll0;
    logic            r_opll1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= {8'd3, 8'd2, 8'd1, 8'd0};
            r_ram_en <= 1'b0;
            r_scc_en <= 1'b0;
            r_opll0  <= 1'b1;
            r_opll1  <= 1'b1;
        end else begin
            if (i_upd_en) begin
                if (i_upd.bank_we) begin
                    r_bank[i_upd.bank_idx] <= i_upd.bank_data;
                end
                if (i_upd.ram_we) begin
                    r_ram_en <= i_upd.ram_val;
                end
                if (i_upd.scc_we) begin
                    r_scc_en <= i_upd.scc_val;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cbm_pkg::CFG_OPLL0: r_opll0 <= i_cfg_wdata;
                    cbm_pkg::CFG_OPLL1: r_opll1 <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign o_state = '{bank: r_bank, ram_en: r_ram_en, scc_en: r_scc_en,
                       opll0: r_opll0, opll1: r_opll1};

endmodule

`default_nettype wire

// File: hdl/cbm_decode.sv
`default_nettype none

module cbm_decode #(
    parameter int RomBanks = cbm_pkg::ROM_BANKS_DEF,
    parameter int RamBanks = cbm_pkg::RAM_BANKS_DEF
) (
    input  wire logic            i_command,
    input  wire logic [15:0]     i_address,
    input  wire logic [7:0]      i_write_data,
    input  wire cbm_pkg::t_state i_state,
    output cbm_pkg::t_result     o_result,
    output cbm_pkg::t_upd        o_upd
);

    // RAM bank index per bank register value, folded at elaboration
    logic [5:0] ram_lut [256];

    for (genvar g = 0; g < 256; g++) begin : g_lut
        assign ram_lut[g] = (g >= RomBanks) ? 6'((g - RomBanks) % RamBanks) : 6'd0;
    end

    logic [2:0]  page;
    logic [7:0]  bank;
    logic        in_scc;
    logic        is_ram;
    logic        in_win;
    logic [20:0] rom_addr;
    logic [20:0] ram_addr;
    logic [20:0] scc_addr;
    logic        ram_next;
    logic        sel;
    logic [2:0]  region;
    logic [1:0]  idx;

    assign page     = i_address[15:13];
    assign bank     = i_state.bank[page[1:0] + 2'd2];
    assign in_scc   = i_state.scc_en && (i_address >= cbm_pkg::SCC_LO)
                      && (i_address < cbm_pkg::SCC_HI);
    assign is_ram   = ((bank & cbm_pkg::SCC_BANK_MASK) != cbm_pkg::SCC_BANK_MASK)
                      && ({24'd0, bank} >= 32'(RomBanks));
    assign in_win   = (i_address >= cbm_pkg::WR_LO) && (i_address < cbm_pkg::WR_HI);
    assign rom_addr = {bank, i_address[12:0]};
    assign ram_addr = {2'd0, ram_lut[bank], i_address[12:0]};
    assign scc_addr = {13'd0, i_address[7:0]};

    always_comb begin
        o_result = '{mem_select: cbm_pkg::MEM_NONE, mem_write: 1'b0,
                     mem_address: 21'd0, opll_select: cbm_pkg::OPLL_NONE,
                     opll_port: 1'b0, data_out: 8'd0, invalidate: 1'b0,
                     invalidate_page: 3'd0};
        o_upd    = '0;
        ram_next = i_state.ram_en;
        sel      = 1'b0;
        region   = 3'd0;
        idx      = 2'd0;

        if (i_command == cbm_pkg::CMD_READ) begin
            if (in_scc) begin
                o_result.mem_select  = cbm_pkg::MEM_SCC;
                o_result.mem_address = scc_addr;
            end else if (is_ram) begin
                o_result.mem_select  = cbm_pkg::MEM_RAM;
                o_result.mem_address = ram_addr;
            end else begin
                o_result.mem_select  = cbm_pkg::MEM_ROM;
                o_result.mem_address = rom_addr;
            end
        end else if (in_win) begin
            if (in_scc) begin
                o_result.mem_select  = cbm_pkg::MEM_SCC;
                o_result.mem_write   = 1'b1;
                o_result.mem_address = scc_addr;
                o_result.data_out    = i_write_data;
            end else begin
                // RAM write sees the enable as it was before this word
                if (i_state.ram_en && is_ram && (i_address >= cbm_pkg::RAM_WR_LO)) begin
                    o_result.mem_select  = cbm_pkg::MEM_RAM;
                    o_result.mem_write   = 1'b1;
                    o_result.mem_address = ram_addr;
                    o_result.data_out    = i_write_data;
                end
                if (((i_address & cbm_pkg::OPLL_MASK) == cbm_pkg::OPLL0_ADDR)
                    && i_state.opll0) begin
                    o_result.opll_select = cbm_pkg::OPLL_0;
                    o_result.opll_port   = i_address[0];
                    o_result.data_out    = i_write_data;
                end
                if (((i_address & cbm_pkg::OPLL_MASK) == cbm_pkg::OPLL1_ADDR)
                    && i_state.opll1) begin
                    o_result.opll_select = cbm_pkg::OPLL_1;
                    o_result.opll_port   = i_address[0];
                    o_result.data_out    = i_write_data;
                end
                if ((i_address & cbm_pkg::RAM_EN_MASK) == cbm_pkg::RAM_EN_ADDR) begin
                    ram_next       = i_write_data[0];
                    o_upd.ram_we   = 1'b1;
                    o_upd.ram_val  = i_write_data[0];
                end
                if (!ram_next
                    && ((i_address & cbm_pkg::BANK0_MASK) == cbm_pkg::BANK0_ADDR)) begin
                    sel    = 1'b1;
                    region = page;
                end else if (ram_next
                    && ((i_address & cbm_pkg::BANK1_MASK) == cbm_pkg::BANK1_ADDR)) begin
                    sel    = 1'b1;
                    region = {1'b0, i_address[1:0]} + 3'd2;
                end
                if (sel) begin
                    idx              = region[1:0] + 2'd2;
                    o_upd.bank_we    = 1'b1;
                    o_upd.bank_idx   = idx;
                    o_upd.bank_data  = i_write_data;
                    if (i_state.bank[idx] != i_write_data) begin
                        o_result.invalidate      = 1'b1;
                        o_result.invalidate_page = region;
                    end
                    if (region == cbm_pkg::SCC_EN_PAGE) begin
                        o_upd.scc_we  = 1'b1;
                        o_upd.scc_val = (i_write_data & cbm_pkg::SCC_BANK_MASK)
                                        == cbm_pkg::SCC_BANK_MASK;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire
